FILE: sv/uoi_pkg.sv
// shared constants and the cordic arctangent table for the odometry integrator
package uoi_pkg;

  localparam int ANGLE_BITS   = 17;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int STEP_W       = $clog2(ATAN_LEN);

  localparam int VEL_W  = 24;
  localparam int DT_W   = 16;
  localparam int POS_W  = 32;
  localparam int Q15_W  = 16;
  localparam int CRD_W  = 34;   // q2.30 cordic datapath with headroom
  localparam int MULA_W = VEL_W + DT_W;
  localparam int MULB_W = Q15_W + 1;
  localparam int PROD_W = MULA_W + MULB_W;

  localparam logic [0:0] KIND_CMD  = 1'b0;
  localparam logic [0:0] KIND_TICK = 1'b1;

  // arctan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/unicycle_odometry_integrator_top.sv
// unicycle dead-reckoning pose integrator with a shared cordic and multiplier
// A command transaction (kind 0) latches speed and turn rate and returns nothing. A tick
// transaction (kind 1) runs a sequencer around one 40x17 multiplier and one cordic stage
// that iterates one step per cycle: speed*dt, cordic of twice the old heading, x and y
// updates, heading update, then cordic of the new heading for the quaternion. in_ready is
// low from acceptance of a tick until its result transaction completes. Positions
// saturate at 32 bits signed; the heading wraps modulo 4*pi.
module unicycle_odometry_integrator_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_kind,
  input  logic signed [uoi_pkg::VEL_W-1:0]       in_linear_velocity,
  input  logic signed [uoi_pkg::VEL_W-1:0]       in_angular_velocity,
  input  logic        [uoi_pkg::DT_W-1:0]        in_elapsed_time,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [uoi_pkg::POS_W-1:0]       out_pos_x,
  output logic signed [uoi_pkg::POS_W-1:0]       out_pos_y,
  output logic        [uoi_pkg::ANGLE_BITS-1:0]  out_heading,
  output logic signed [uoi_pkg::Q15_W-1:0]       out_quat_z,
  output logic signed [uoi_pkg::Q15_W-1:0]       out_quat_w
);

  typedef enum logic [3:0] {
    S_IDLE, S_VDT, S_ROT_A, S_FIN_A, S_MUL_X, S_MUL_Y, S_ADD_Y, S_HEAD,
    S_ROT_B, S_FIN_B, S_OUT
  } state_t;

  localparam int AB = uoi_pkg::ANGLE_BITS;
  localparam int CW = uoi_pkg::CRD_W;
  localparam int PW = uoi_pkg::PROD_W;
  localparam logic [uoi_pkg::STEP_W-1:0] LAST_STEP = uoi_pkg::STEP_W'(uoi_pkg::CORDIC_STEPS - 1);
  localparam logic signed [CW-1:0] QUARTER = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF    = CW'(64'sd2147483648);
  localparam logic signed [CW-1:0] X_INIT  = CW'(64'sd652032874);
  localparam logic signed [CW-1:0] Q_RND   = CW'(64'sd16384);
  localparam logic signed [PW-1:0] POS_RND = PW'(64'sd1073741824);
  localparam logic signed [PW-1:0] HDG_RND = PW'(64'sd32768);

  state_t state_r;
  logic   out_valid_r;

  logic signed [uoi_pkg::POS_W-1:0]  x_r, y_r;
  logic        [AB-1:0]              heading_r;
  logic signed [uoi_pkg::VEL_W-1:0]  speed_r, turn_r;
  logic        [uoi_pkg::DT_W-1:0]   dt_r;
  logic signed [uoi_pkg::MULA_W-1:0] vdt_r;
  logic signed [PW-1:0]              prod_r;
  logic signed [uoi_pkg::Q15_W-1:0]  sin_r, cos_r, qz_r, qw_r;

  logic signed [CW-1:0]              cx_r, cy_r, cz_r;
  logic                              neg_r;
  logic        [uoi_pkg::STEP_W-1:0] step_r;

  // shared multiplier
  logic signed [uoi_pkg::MULA_W-1:0] mul_a;
  logic signed [uoi_pkg::MULB_W-1:0] mul_b;
  logic signed [PW-1:0]              mul_p;

  always_comb begin
    case (state_r)
      S_VDT: begin
        mul_a = uoi_pkg::MULA_W'(speed_r);
        mul_b = $signed({1'b0, dt_r});
      end
      S_MUL_X: begin
        mul_a = vdt_r;
        mul_b = uoi_pkg::MULB_W'(cos_r);
      end
      S_MUL_Y: begin
        mul_a = vdt_r;
        mul_b = uoi_pkg::MULB_W'(sin_r);
      end
      default: begin
        mul_a = uoi_pkg::MULA_W'(turn_r);
        mul_b = $signed({1'b0, dt_r});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // position accumulate with rounding and saturation
  function automatic logic signed [uoi_pkg::POS_W-1:0] pos_add(
    input logic signed [uoi_pkg::POS_W-1:0] pos,
    input logic signed [PW-1:0]             p
  );
    logic signed [PW-1:0] rnd;
    logic signed [CW-1:0] sum;
    logic signed [uoi_pkg::POS_W-1:0] res;
    rnd = p + POS_RND;
    sum = CW'(pos) + CW'($signed(rnd[PW-1:31]));
    if (sum > CW'(64'sd2147483647)) begin
      res = {1'b0, {(uoi_pkg::POS_W-1){1'b1}}};
    end else if (sum < -CW'(64'sd2147483648)) begin
      res = {1'b1, {(uoi_pkg::POS_W-1){1'b0}}};
    end else begin
      res = sum[uoi_pkg::POS_W-1:0];
    end
    return res;
  endfunction

  // q2.30 to q1.15 with rounding and saturation, after undoing the fold
  function automatic logic signed [uoi_pkg::Q15_W-1:0] to_q15(
    input logic signed [CW-1:0] v,
    input logic                 neg
  );
    logic signed [CW-1:0] t;
    logic signed [CW-16:0] r;
    logic signed [uoi_pkg::Q15_W-1:0] res;
    t = (neg ? -v : v) + Q_RND;
    r = t[CW-1:15];
    if (r > (CW-15)'(32767)) begin
      res = 16'sh7fff;
    end else if (r < -(CW-15)'(32768)) begin
      res = -16'sh8000;
    end else begin
      res = r[uoi_pkg::Q15_W-1:0];
    end
    return res;
  endfunction

  // heading update and cordic load angle
  logic signed [PW-1:0] hdg_sum;
  logic        [AB-1:0] head_nxt;
  logic        [AB-1:0] load_angle;
  logic        [31:0]   a32;
  logic signed [CW-1:0] z_raw, z_nxt;
  logic                 neg_nxt;

  assign hdg_sum  = prod_r + HDG_RND;
  assign head_nxt = heading_r + hdg_sum[16 +: AB];
  // twice the heading, modulo the angle range, is the full angle theta
  assign load_angle = (state_r == S_VDT) ? {heading_r[AB-2:0], 1'b0} : head_nxt;
  assign a32   = {load_angle, {(32-AB){1'b0}}};
  assign z_raw = CW'($signed(a32));

  always_comb begin
    if (z_raw > QUARTER) begin
      z_nxt   = z_raw - HALF;
      neg_nxt = 1'b1;
    end else if (z_raw < -QUARTER) begin
      z_nxt   = z_raw + HALF;
      neg_nxt = 1'b1;
    end else begin
      z_nxt   = z_raw;
      neg_nxt = 1'b0;
    end
  end

  // one cordic rotation step
  logic signed [CW-1:0] xs, ys, atan_v;
  logic signed [CW-1:0] cx_nxt, cy_nxt, cz_nxt;

  assign xs     = cx_r >>> step_r;
  assign ys     = cy_r >>> step_r;
  assign atan_v = CW'(uoi_pkg::atan_entry(step_r));

  always_comb begin
    if (!cz_r[CW-1]) begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      cz_nxt = cz_r - atan_v;
    end else begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      cz_nxt = cz_r + atan_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      x_r         <= '0;
      y_r         <= '0;
      heading_r   <= '0;
      speed_r     <= '0;
      turn_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_kind == uoi_pkg::KIND_CMD) begin
              speed_r <= in_linear_velocity;
              turn_r  <= in_angular_velocity;
            end else begin
              dt_r    <= in_elapsed_time;
              state_r <= S_VDT;
            end
          end
        end
        S_VDT: begin
          prod_r  <= mul_p;
          cx_r    <= X_INIT;
          cy_r    <= '0;
          cz_r    <= z_nxt;
          neg_r   <= neg_nxt;
          step_r  <= '0;
          state_r <= S_ROT_A;
        end
        S_ROT_A: begin
          vdt_r  <= prod_r[uoi_pkg::MULA_W-1:0];
          cx_r   <= cx_nxt;
          cy_r   <= cy_nxt;
          cz_r   <= cz_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == LAST_STEP) begin
            state_r <= S_FIN_A;
          end
        end
        S_FIN_A: begin
          cos_r   <= to_q15(cx_r, neg_r);
          sin_r   <= to_q15(cy_r, neg_r);
          state_r <= S_MUL_X;
        end
        S_MUL_X: begin
          prod_r  <= mul_p;
          state_r <= S_MUL_Y;
        end
        S_MUL_Y: begin
          prod_r  <= mul_p;
          x_r     <= pos_add(x_r, prod_r);
          state_r <= S_ADD_Y;
        end
        S_ADD_Y: begin
          prod_r  <= mul_p;
          y_r     <= pos_add(y_r, prod_r);
          state_r <= S_HEAD;
        end
        S_HEAD: begin
          heading_r <= head_nxt;
          cx_r      <= X_INIT;
          cy_r      <= '0;
          cz_r      <= z_nxt;
          neg_r     <= neg_nxt;
          step_r    <= '0;
          state_r   <= S_ROT_B;
        end
        S_ROT_B: begin
          cx_r   <= cx_nxt;
          cy_r   <= cy_nxt;
          cz_r   <= cz_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == LAST_STEP) begin
            state_r <= S_FIN_B;
          end
        end
        S_FIN_B: begin
          qw_r        <= to_q15(cx_r, neg_r);
          qz_r        <= to_q15(cy_r, neg_r);
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_pos_x   = x_r;
  assign out_pos_y   = y_r;
  assign out_heading = heading_r;
  assign out_quat_z  = qz_r;
  assign out_quat_w  = qw_r;

endmodule
